[hw/rtl/vfa_pkg.sv]
// Package for the forced aligner: defaults, register map, result codes and control states.
package vfa_pkg;

    localparam int DEF_MAX_STATES = 64;
    localparam int DEF_MAX_FRAMES = 1024;

    localparam int SCORE_W = 32;
    localparam int EM_W    = 24;
    localparam int BEAM_W  = 24;
    localparam int PADDR_W = 4;

    localparam logic [PADDR_W-1:0] ADDR_NUM_STATES = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_NUM_FRAMES = 4'h4;
    localparam logic [PADDR_W-1:0] ADDR_BEAM_WIDTH = 4'h8;
    localparam logic [PADDR_W-1:0] ADDR_BEAM_EN    = 4'hC;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_FEW_FRAMES = 2'd1;
    localparam logic [1:0] ERR_END_CELL  = 2'd2;

    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_BT_RD,
        ST_BT_CHK,
        ST_BT_LAST
    } vfa_state_t;

endpackage

[hw/rtl/vfa_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module vfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/viterbi_forced_aligner.sv]
// Forced aligner for a left-to-right state chain: Viterbi pass and backtrace.
//
// Scores enter on emission_score with start; a request is taken when start is
// high and busy is low. They come frame by frame, state 0 upward within a frame,
// num_states * num_frames requests per alignment. Each request reads the column
// score memory, then does the add-compare-select and the write back in ST_CALC;
// busy is high there, so a new score is taken only once the previous is written back.
// After the last score of the last frame the backtrace reads one backpointer row
// per pass through ST_BT_RD and ST_BT_CHK, from the last frame down to frame 1 at
// most, and emits one segment per state, last state first. Each result is shown
// for one cycle with result_valid; the last carries last = 1.
// An alignment with too few frames or an unreachable end cell ends with a single
// error result. The receiver cannot stall results; none is held back.
// Reset clears the configuration to its defaults and restarts the alignment;
// a write to any of the four configuration registers restarts it too. The column
// valid marks live in flip-flops, so no clearing pass is needed.
module viterbi_forced_aligner #(
    parameter int MAX_STATES = vfa_pkg::DEF_MAX_STATES,
    parameter int MAX_FRAMES = vfa_pkg::DEF_MAX_FRAMES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vfa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [23:0]          emission_score,
    output logic                        result_valid,
    output logic [5:0]                  state_index,
    output logic [9:0]                  begin_frame,
    output logic [9:0]                  end_frame,
    output logic signed [31:0]          total_score,
    output logic [1:0]                  error_code,
    output logic                        last
);

    import vfa_pkg::*;

    localparam int SW  = $clog2(MAX_STATES);
    localparam int FW  = $clog2(MAX_FRAMES);
    localparam int SCW = SW + 1;
    localparam int FCW = (FW + 1 > 11) ? FW + 1 : 11;
    localparam int CW  = ((SCW > FCW) ? SCW : FCW) + 1;

    logic [6:0]        num_states_reg;
    logic [10:0]       num_frames_reg;
    logic [BEAM_W-1:0] beam_width_reg;
    logic              beam_enable_reg;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr)
            ADDR_NUM_STATES: prdata = {25'd0, num_states_reg};
            ADDR_NUM_FRAMES: prdata = {21'd0, num_frames_reg};
            ADDR_BEAM_WIDTH: prdata = {8'd0, beam_width_reg};
            ADDR_BEAM_EN:    prdata = {31'd0, beam_enable_reg};
            default:         prdata = 32'd0;
        endcase
    end

    logic cfg_hit;
    assign cfg_hit = cfg_wr && (paddr == ADDR_NUM_STATES || paddr == ADDR_NUM_FRAMES ||
                                paddr == ADDR_BEAM_WIDTH || paddr == ADDR_BEAM_EN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_states_reg  <= 7'd1;
            num_frames_reg  <= 11'd1;
            beam_width_reg  <= '0;
            beam_enable_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr)
                ADDR_NUM_STATES: num_states_reg  <= pwdata[6:0];
                ADDR_NUM_FRAMES: num_frames_reg  <= pwdata[10:0];
                ADDR_BEAM_WIDTH: beam_width_reg  <= pwdata[BEAM_W-1:0];
                ADDR_BEAM_EN:    beam_enable_reg <= pwdata[0];
                default:         ;
            endcase
        end
    end

    // Effective chain length and frame count, clamped to the supported range.
    logic [SCW-1:0] s_eff;
    logic [FCW-1:0] f_eff;
    always_comb
    begin
        if (num_states_reg == 7'd0)
            s_eff = SCW'(1);
        else if (32'(num_states_reg) > MAX_STATES)
            s_eff = SCW'(MAX_STATES);
        else
            s_eff = SCW'(num_states_reg);
        if (num_frames_reg == 11'd0)
            f_eff = FCW'(1);
        else if (32'(num_frames_reg) > MAX_FRAMES)
            f_eff = FCW'(MAX_FRAMES);
        else
            f_eff = FCW'(num_frames_reg);
    end

    logic few_frames;
    assign few_frames = (FCW'(s_eff) > f_eff);

    vfa_state_t state_reg, state_next;

    logic [FW-1:0]               t_reg;
    logic [SW-1:0]               i_reg;
    logic signed [EM_W-1:0]      em_reg;
    logic [MAX_STATES-1:0]       col_valid_reg;
    logic signed [SCORE_W-1:0]   frame_best_reg, prev_best_reg, carry_score_reg;
    logic                        prev_prune_reg, carry_valid_reg;
    logic [MAX_STATES-1:0]       row_reg;
    logic [SW-1:0]               bt_s_reg;
    logic [FW-1:0]               bt_t_reg, seg_end_reg;
    logic signed [SCORE_W-1:0]   total_reg;

    logic signed [SCORE_W-1:0]   col_rdata;
    logic [MAX_STATES-1:0]       bp_rdata;

    logic accept;
    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // Add-compare-select for the cell under way.
    logic                        stay_ok, adv_ok, skip, first_cell, nvalid, adv;
    logic                        pruned, end_of_frame, end_of_seq;
    logic signed [SCORE_W+1:0]   sc_ext, thr_ext;
    logic signed [SCORE_W-1:0]   sel_sc, nscore;
    logic signed [SCORE_W:0]     sum;
    logic [CW-1:0]               i_w, t_w;
    logic [MAX_STATES-1:0]       row_next;

    always_comb
    begin
        i_w     = CW'(i_reg);
        t_w     = CW'(t_reg);
        sc_ext  = {{2{col_rdata[SCORE_W-1]}}, col_rdata};
        thr_ext = {{2{prev_best_reg[SCORE_W-1]}}, prev_best_reg} -
                  $signed({{(SCORE_W+2-BEAM_W){1'b0}}, beam_width_reg});
        pruned  = prev_prune_reg && (sc_ext < thr_ext);
        stay_ok = (t_reg != '0) && col_valid_reg[i_reg] && !pruned;
        adv_ok  = (t_reg != '0) && (i_reg != '0) && carry_valid_reg;
        first_cell = (t_reg == '0) && (i_reg == '0);
        // The cell is off every path that can still reach the last state in time.
        skip = (i_w > t_w) || (CW'(f_eff) + i_w < CW'(s_eff) + t_w);
        adv = 1'b0;
        nvalid = 1'b0;
        sel_sc = col_rdata;
        if (first_cell)
        begin
            nvalid = 1'b1;
            sel_sc = '0;
        end
        else if (skip)
        begin
            nvalid = 1'b0;
        end
        else if (stay_ok && (!adv_ok || col_rdata > carry_score_reg))
        begin
            nvalid = 1'b1;
        end
        else if (adv_ok)
        begin
            nvalid = 1'b1;
            adv    = 1'b1;
            sel_sc = carry_score_reg;
        end
        sum = {sel_sc[SCORE_W-1], sel_sc} +
              {{(SCORE_W+1-EM_W){em_reg[EM_W-1]}}, em_reg};
        if (sum > $signed({1'b0, SCORE_MAX}))
            nscore = SCORE_MAX;
        else if (sum < $signed({1'b1, SCORE_MIN}))
            nscore = SCORE_MIN;
        else
            nscore = sum[SCORE_W-1:0];
        row_next = row_reg;
        row_next[i_reg] = adv;
        end_of_frame = (SCW'(i_reg) + SCW'(1) == s_eff);
        end_of_seq   = end_of_frame && (FCW'(t_reg) + FCW'(1) == f_eff);
    end

    logic signed [SCORE_W-1:0] best_upd;
    assign best_upd = (nvalid && nscore > frame_best_reg) ? nscore : frame_best_reg;

    logic calc;
    assign calc = (state_reg == ST_CALC);

    vfa_ram #(
        .WIDTH(SCORE_W),
        .DEPTH(MAX_STATES)
    ) u_column (
        .clk  (clk),
        .we   (calc),
        .waddr(i_reg),
        .wdata(nvalid ? nscore : '0),
        .raddr(i_reg),
        .rdata(col_rdata)
    );

    vfa_ram #(
        .WIDTH(MAX_STATES),
        .DEPTH(MAX_FRAMES)
    ) u_backptr (
        .clk  (clk),
        .we   (calc && end_of_frame),
        .waddr(t_reg),
        .wdata(row_next),
        .raddr(bt_t_reg),
        .rdata(bp_rdata)
    );

    logic bt_bit;
    assign bt_bit = bp_rdata[bt_s_reg];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_CALC;
            ST_CALC:
                if (end_of_seq && !few_frames && nvalid
                    && t_reg != '0 && i_reg != '0)
                    state_next = ST_BT_RD;
                else if (end_of_seq && !few_frames && nvalid)
                    state_next = ST_BT_LAST;
                else
                    state_next = ST_IDLE;
            ST_BT_RD:
                state_next = ST_BT_CHK;
            ST_BT_CHK:
                if (bt_t_reg == FW'(1) || (bt_bit && bt_s_reg == SW'(1)))
                    state_next = ST_BT_LAST;
                else
                    state_next = ST_BT_RD;
            ST_BT_LAST:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
        if (cfg_hit)
            state_next = ST_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    logic restart;
    assign restart = cfg_hit || (calc && end_of_seq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg           <= '0;
            i_reg           <= '0;
            col_valid_reg   <= '0;
            frame_best_reg  <= SCORE_MIN;
            prev_best_reg   <= SCORE_MIN;
            prev_prune_reg  <= 1'b0;
            carry_valid_reg <= 1'b0;
            carry_score_reg <= '0;
        end
        else if (restart)
        begin
            t_reg           <= '0;
            i_reg           <= '0;
            col_valid_reg   <= '0;
            frame_best_reg  <= SCORE_MIN;
            prev_best_reg   <= SCORE_MIN;
            prev_prune_reg  <= 1'b0;
            carry_valid_reg <= 1'b0;
            carry_score_reg <= '0;
        end
        else if (calc)
        begin
            col_valid_reg[i_reg] <= nvalid;
            if (end_of_frame)
            begin
                i_reg           <= '0;
                t_reg           <= t_reg + FW'(1);
                prev_best_reg   <= best_upd;
                prev_prune_reg  <= (t_reg != '0) && beam_enable_reg;
                frame_best_reg  <= SCORE_MIN;
                carry_valid_reg <= 1'b0;
                carry_score_reg <= '0;
            end
            else
            begin
                i_reg           <= i_reg + SW'(1);
                frame_best_reg  <= best_upd;
                carry_valid_reg <= stay_ok;
                carry_score_reg <= (t_reg != '0) ? col_rdata : '0;
            end
        end
    end

    // Payload registers of the datapath and the backtrace.
    always_ff @(posedge clk)
    begin
        if (accept)
            em_reg <= emission_score;
        if (calc)
        begin
            row_reg <= end_of_frame ? '0 : row_next;
            if (end_of_seq)
            begin
                bt_s_reg    <= i_reg;
                bt_t_reg    <= t_reg;
                seg_end_reg <= t_reg;
                total_reg   <= nscore;
            end
        end
        else if (state_reg == ST_BT_CHK)
        begin
            bt_t_reg <= bt_t_reg - FW'(1);
            if (bt_bit)
            begin
                bt_s_reg    <= bt_s_reg - SW'(1);
                seg_end_reg <= bt_t_reg - FW'(1);
            end
        end
    end

    // Result register: each result is valid for a single cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
            last         <= 1'b0;
            error_code   <= ERR_OK;
        end
        else
        begin
            result_valid <= 1'b0;
            if (calc && end_of_seq && few_frames)
            begin
                result_valid <= 1'b1;
                state_index  <= '0;
                begin_frame  <= '0;
                end_frame    <= '0;
                total_score  <= '0;
                error_code   <= ERR_FEW_FRAMES;
                last         <= 1'b1;
            end
            else if (calc && end_of_seq && !nvalid)
            begin
                result_valid <= 1'b1;
                state_index  <= '0;
                begin_frame  <= '0;
                end_frame    <= '0;
                total_score  <= '0;
                error_code   <= ERR_END_CELL;
                last         <= 1'b1;
            end
            else if (state_reg == ST_BT_CHK && bt_bit)
            begin
                result_valid <= 1'b1;
                state_index  <= 6'(bt_s_reg);
                begin_frame  <= 10'(bt_t_reg);
                end_frame    <= 10'(seg_end_reg);
                total_score  <= total_reg;
                error_code   <= ERR_OK;
                last         <= 1'b0;
            end
            else if (state_reg == ST_BT_LAST)
            begin
                result_valid <= 1'b1;
                state_index  <= 6'(bt_s_reg);
                begin_frame  <= '0;
                end_frame    <= 10'(seg_end_reg);
                total_score  <= total_reg;
                error_code   <= ERR_OK;
                last         <= 1'b1;
            end
        end
    end

    a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cfg_hit |=> state_reg == ST_CALC)
        else $error("accepted request did not enter the compute cycle");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && error_code != ERR_OK |-> last)
        else $error("error result not marked last");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
        else $error("result right after the final result");

    a_bt_idle_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BT_RD || state_reg == ST_BT_CHK) |-> busy)
        else $error("input open during backtrace");

endmodule

[test/vfa_checker.sv]
// Checker for the forced aligner: watches the ports, predicts segments and compares them.
module vfa_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [vfa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        start,
    input  logic                        busy,
    input  logic signed [23:0]          emission_score,
    input  logic                        result_valid,
    input  logic [5:0]                  state_index,
    input  logic [9:0]                  begin_frame,
    input  logic [9:0]                  end_frame,
    input  logic signed [31:0]          total_score,
    input  logic [1:0]                  error_code,
    input  logic                        last,
    output int                          fail_count,
    output int                          pending
);
    import vfa_pkg::*;

    typedef struct packed {
        logic [5:0]         st;
        logic [9:0]         bf;
        logic [9:0]         ef;
        logic signed [31:0] tot;
        logic [1:0]         err;
        logic               lst;
    } segment_t;

    segment_t segments_due[$];

    logic [6:0]  cfg_states;
    logic [10:0] cfg_frames;
    logic [23:0] cfg_beam;
    logic        cfg_beam_en;

    logic signed [31:0] col_score [64];
    logic               col_valid [64];
    logic [63:0]        bp_rows [1024];
    logic signed [31:0] best_now;
    logic signed [31:0] best_prev;
    logic               prev_prunable;
    logic               carry_ok;
    logic signed [31:0] carry_sc;
    int                 frame_no;
    int                 state_no;

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return SCORE_MAX;
        if (v < -64'sd2147483648) return SCORE_MIN;
        return v[31:0];
    endfunction

    function automatic int chain_len();
        if (cfg_states < 1) return 1;
        if (cfg_states > 64) return 64;
        return int'(cfg_states);
    endfunction

    function automatic int frame_len();
        if (cfg_frames < 1) return 1;
        if (cfg_frames > 1024) return 1024;
        return int'(cfg_frames);
    endfunction

    function automatic logic survives(logic ok, logic signed [31:0] sc);
        if (!ok) return 1'b0;
        if (prev_prunable && longint'(sc) < longint'(best_prev) - longint'(cfg_beam))
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic clear_trellis();
        for (int k = 0; k < 64; k++)
        begin
            col_score[k] = '0;
            col_valid[k] = 1'b0;
        end
        best_now = SCORE_MIN;
        best_prev = SCORE_MIN;
        prev_prunable = 1'b0;
        carry_ok = 1'b0;
        carry_sc = '0;
        frame_no = 0;
        state_no = 0;
    endtask

    task automatic add_segment(int st, int bf, int ef, logic signed [31:0] tot,
                               logic [1:0] err, logic lst);
        segment_t sg;
        sg.st = st[5:0];
        sg.bf = bf[9:0];
        sg.ef = ef[9:0];
        sg.tot = tot;
        sg.err = err;
        sg.lst = lst;
        segments_due.insert(segments_due.size(), sg);
    endtask

    task automatic backtrace();
        int                 ns;
        int                 nf;
        int                 s;
        int                 seg_end;
        logic signed [31:0] total;
        ns = chain_len();
        nf = frame_len();
        if (ns > nf)
            add_segment(0, 0, 0, '0, ERR_FEW_FRAMES, 1'b1);
        else if (!col_valid[ns-1])
            add_segment(0, 0, 0, '0, ERR_END_CELL, 1'b1);
        else
        begin
            total = col_score[ns-1];
            s = ns - 1;
            seg_end = nf - 1;
            for (int t = nf - 1; t >= 1 && s > 0; t--)
            begin
                if (bp_rows[t][s])
                begin
                    add_segment(s, t, seg_end, total, ERR_OK, 1'b0);
                    s--;
                    seg_end = t - 1;
                end
            end
            add_segment(s, 0, seg_end, total, ERR_OK, 1'b1);
        end
        clear_trellis();
    endtask

    task automatic score_cell(logic signed [23:0] em);
        int                 ns;
        int                 nf;
        int                 t;
        int                 i;
        logic               stay_ok;
        logic               adv_ok;
        logic               nvalid;
        logic               adv;
        logic signed [31:0] stay_sc;
        logic signed [31:0] adv_sc;
        logic signed [31:0] nscore;
        ns = chain_len();
        nf = frame_len();
        t = frame_no;
        i = state_no;
        stay_ok = 1'b0;
        adv_ok = 1'b0;
        nvalid = 1'b0;
        adv = 1'b0;
        stay_sc = '0;
        adv_sc = '0;
        nscore = '0;
        if (t > 0)
        begin
            stay_ok = survives(col_valid[i], col_score[i]);
            stay_sc = col_score[i];
            adv_ok = (i > 0) && carry_ok;
            adv_sc = carry_sc;
        end
        // The old value of this state feeds the advance move of the next state.
        carry_ok = stay_ok;
        carry_sc = stay_sc;
        if (t == 0 && i == 0)
        begin
            nvalid = 1'b1;
            nscore = sat32(longint'(em));
        end
        else if (i > t || (nf - 1 - t) < (ns - 1 - i))
            nvalid = 1'b0;
        else if (stay_ok && (!adv_ok || stay_sc > adv_sc))
        begin
            nvalid = 1'b1;
            nscore = sat32(longint'(stay_sc) + longint'(em));
        end
        else if (adv_ok)
        begin
            nvalid = 1'b1;
            adv = 1'b1;
            nscore = sat32(longint'(adv_sc) + longint'(em));
        end
        bp_rows[t][i] = adv;
        col_valid[i] = nvalid;
        col_score[i] = nvalid ? nscore : '0;
        if (nvalid && nscore > best_now)
            best_now = nscore;
        state_no++;
        if (state_no >= ns)
        begin
            state_no = 0;
            best_prev = best_now;
            prev_prunable = (t >= 1) && cfg_beam_en;
            best_now = SCORE_MIN;
            carry_ok = 1'b0;
            carry_sc = '0;
            frame_no++;
            if (frame_no >= nf)
                backtrace();
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        segment_t sg;
        if (!rst_n)
        begin
            cfg_states = 7'd1;
            cfg_frames = 11'd1;
            cfg_beam = '0;
            cfg_beam_en = 1'b0;
            clear_trellis();
            segments_due.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (segments_due.size() == 0)
                    report_mismatch("unexpected result, state", state_index, 0);
                else
                begin
                    sg = segments_due.pop_front();
                    if (state_index !== sg.st)
                        report_mismatch("state_index", state_index, sg.st);
                    if (begin_frame !== sg.bf)
                        report_mismatch("begin_frame", begin_frame, sg.bf);
                    if (end_frame !== sg.ef)
                        report_mismatch("end_frame", end_frame, sg.ef);
                    if (total_score !== sg.tot)
                        report_mismatch("total_score", total_score, sg.tot);
                    if (error_code !== sg.err)
                        report_mismatch("error_code", error_code, sg.err);
                    if (last !== sg.lst)
                        report_mismatch("last", last, sg.lst);
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    ADDR_NUM_STATES: cfg_states = pwdata[6:0];
                    ADDR_NUM_FRAMES: cfg_frames = pwdata[10:0];
                    ADDR_BEAM_WIDTH: cfg_beam = pwdata[23:0];
                    ADDR_BEAM_EN:    cfg_beam_en = pwdata[0];
                    default: ;
                endcase
                if (paddr == ADDR_NUM_STATES || paddr == ADDR_NUM_FRAMES ||
                    paddr == ADDR_BEAM_WIDTH || paddr == ADDR_BEAM_EN)
                    clear_trellis();
            end
            if (start && !busy)
                score_cell(emission_score);
            pending = segments_due.size();
        end
    end
endmodule

[test/tb_viterbi_forced_aligner.sv]
// Testbench top for the forced aligner: clock, reset, stimulus and verdict.
module tb_viterbi_forced_aligner;
    import vfa_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic signed [23:0] emission_score;
    logic               result_valid;
    logic [5:0]         state_index;
    logic [9:0]         begin_frame;
    logic [9:0]         end_frame;
    logic signed [31:0] total_score;
    logic [1:0]         error_code;
    logic               last;
    int                 fail_count;
    int                 pending;
    int                 idle_pct;
    int                 quiet_cycles;
    int                 items_sent;

    viterbi_forced_aligner i_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .emission_score(emission_score),
        .result_valid(result_valid), .state_index(state_index),
        .begin_frame(begin_frame), .end_frame(end_frame), .total_score(total_score),
        .error_code(error_code), .last(last)
    );

    vfa_checker i_checker (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .pready(pready), .paddr(paddr), .pwdata(pwdata), .start(start), .busy(busy),
        .emission_score(emission_score), .result_valid(result_valid),
        .state_index(state_index), .begin_frame(begin_frame), .end_frame(end_frame),
        .total_score(total_score), .error_code(error_code), .last(last),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Watchdog: any cycle without an accepted request, write or result counts.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (psel && penable && pwrite))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** viterbi_forced_aligner: FAILED **");
            $finish;
        end
    end

    task automatic reg_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic push_score(logic signed [23:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            emission_score <= 24'($urandom);
            @(posedge clk);
        end
        start <= 1'b1;
        emission_score <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    // Waits until every expected segment is out and the block is idle again.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic signed [23:0] pick_score(int mode);
        case (mode)
            0: return 24'($urandom);
            1: return $signed(24'($urandom_range(6))) - 24'sd3;
            2: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            3: return 24'sh7FFFFF;
            default: return $signed(24'($urandom_range(2000))) - 24'sd1000;
        endcase
    endfunction

    task automatic align(int ns, int nf, int beam, int beam_en, int mode);
        int s_eff;
        int f_eff;
        drain();
        reg_write(ADDR_NUM_STATES, 32'(ns));
        reg_write(ADDR_NUM_FRAMES, 32'(nf));
        reg_write(ADDR_BEAM_WIDTH, 32'(beam));
        reg_write(ADDR_BEAM_EN, 32'(beam_en));
        s_eff = (ns < 1) ? 1 : (ns > 64) ? 64 : ns;
        f_eff = (nf < 1) ? 1 : (nf > 1024) ? 1024 : nf;
        for (int k = 0; k < s_eff * f_eff; k++)
            push_score(pick_score(mode));
    endtask

    initial
    begin
        int ns;
        int nf;
        int phase;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        emission_score = '0;
        quiet_cycles = 0;
        items_sent = 0;
        idle_pct = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single cell at both extremes, too few frames, ties, tight beam.
        align(1, 1, 0, 0, 3);
        align(1, 1, 0, 0, 2);
        align(3, 2, 0, 0, 0);
        align(2, 3, 0, 0, 1);
        align(3, 4, 0, 1, 1);
        align(0, 0, 24'hFFFFFF, 1, 0);
        // Clamped chain length with too few frames, and extreme scores.
        idle_pct = 28;
        align(127, 2, 24'hFFFFFF, 1, 0);
        idle_pct = 0;
        align(8, 12, 0, 0, 2);

        phase = 0;
        while (items_sent < 350)
        begin
            idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 60 : 28;
            ns = $urandom_range(6, 1);
            nf = ns + $urandom_range(8) - 1;
            if ($urandom_range(9) == 0)
                ns = $urandom_range(9);
            if ($urandom_range(9) == 0)
                nf = $urandom_range(12);
            align(ns, nf, $urandom_range(3) == 0 ? $urandom_range(24'hFFFFFF)
                                                 : $urandom_range(600),
                  $urandom_range(1), $urandom_range(4));
            phase++;
        end
        drain();
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** viterbi_forced_aligner: PASSED **");
        else
            $display("** viterbi_forced_aligner: FAILED **");
        $finish;
    end
endmodule

[viterbi_forced_aligner.f]
hw/rtl/vfa_pkg.sv
hw/rtl/vfa_ram.sv
hw/rtl/viterbi_forced_aligner.sv
test/vfa_checker.sv
test/tb_viterbi_forced_aligner.sv
